// ===== src/provider_median_tracker_core_macros.svh =====
// Assertion macros shared by the provider median tracker RTL.
`ifndef PROVIDER_MEDIAN_TRACKER_CORE_MACROS_SVH
`define PROVIDER_MEDIAN_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PMT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/pmt_pkg.sv =====
// Package with constants, types and state codes of the provider median tracker.
package pmt_pkg;

  localparam int DEF_MAX_PROVIDERS = 32;
  localparam int DEF_VALUE_WIDTH   = 64;
  localparam int IDX_W             = 5;
  localparam int COUNT_W           = 6;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 1'b1;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_PV,
    S_FIND,
    S_UP,
    S_DN,
    S_MED0,
    S_MED1,
    S_MED2,
    S_DONE
  } pmt_state_e;

  typedef struct packed {
    logic filling;
    logic busy;
  } pmt_stat_t;

endpackage

// ===== src/pmt_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
interface pmt_in_if #(
  parameter int VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic [4:0]             provider_index;
  logic [VALUE_WIDTH-1:0] new_value;

  modport source (output valid, provider_index, new_value, input ready);
  modport sink   (input valid, provider_index, new_value, output ready);
endinterface

interface pmt_out_if #(
  parameter int VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] median_value;
  logic                   bad_provider;

  modport source (output valid, median_value, bad_provider, input ready);
  modport sink   (input valid, median_value, bad_provider, output ready);
endinterface

// ===== src/pmt_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module pmt_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pmt_ctrl.sv =====
// Sequencer: refill sweep, provider lookup, sorted-list shift and median read.
module pmt_ctrl import pmt_pkg::*; #(
  parameter int MAX_PROVIDERS = DEF_MAX_PROVIDERS,
  parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
  parameter int AW            = 5,
  parameter int NW            = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_i,
  input  logic [NW-1:0]          n_i,
  input  logic [VALUE_WIDTH-1:0] init_i,
  pmt_in_if.sink                 in_if,
  pmt_out_if.source              out_if,
  output logic                   pv_we_o,
  output logic [AW-1:0]          pv_waddr_o,
  output logic [VALUE_WIDTH-1:0] pv_wdata_o,
  output logic                   pv_re_o,
  output logic [AW-1:0]          pv_raddr_o,
  input  logic [VALUE_WIDTH-1:0] pv_rdata_i,
  output logic                   s_we_o,
  output logic [AW-1:0]          s_waddr_o,
  output logic [VALUE_WIDTH-1:0] s_wdata_o,
  output logic                   s_re_o,
  output logic [AW-1:0]          s_raddr_o,
  input  logic [VALUE_WIDTH-1:0] s_rdata_i,
  output pmt_stat_t              stat_o
);

  localparam int CW = (NW > IDX_W) ? NW : IDX_W;
  localparam logic [AW-1:0] LAST = AW'(MAX_PROVIDERS - 1);

  pmt_state_e state_q, state_d;
  logic [AW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          k_q, k_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] old_q, old_d;
  logic [VALUE_WIDTH-1:0] hi_q, hi_d;
  logic [VALUE_WIDTH-1:0] median_q, median_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_med_q, out_med_d;
  logic                   out_bad_q, out_bad_d;

  logic          slot_free, accept, bad_in, pv_eq, s_eq, go_up, up_more, dn_more, odd;
  logic [NW-1:0] k1, mid;

  assign slot_free    = !out_valid_q || out_if.ready;
  assign in_if.ready  = (state_q == S_IDLE) && slot_free;
  assign accept       = in_if.valid && in_if.ready;
  assign bad_in       = CW'(in_if.provider_index) >= CW'(n_i);
  assign pv_eq        = pv_rdata_i == val_q;
  assign s_eq         = s_rdata_i == old_q;
  assign go_up        = val_q > old_q;
  assign k1           = NW'(k_q) + NW'(1);
  assign up_more      = (k1 < n_i) && (s_rdata_i < val_q);
  assign dn_more      = (k_q != '0) && (s_rdata_i > val_q);
  assign odd          = n_i[0];
  assign mid          = n_i >> 1;

  assign out_if.valid        = out_valid_q;
  assign out_if.median_value = out_med_q;
  assign out_if.bad_provider = out_bad_q;

  assign stat_o.filling = state_q == S_FILL;
  assign stat_o.busy    = state_q != S_IDLE;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_FILL: if (fill_q == LAST) state_d = S_IDLE;
      S_IDLE: if (accept && !bad_in) state_d = S_PV;
      S_PV:   state_d = pv_eq ? S_DONE : S_FIND;
      S_FIND: if (s_eq) state_d = go_up ? S_UP : S_DN;
      S_UP:   if (!up_more) state_d = S_MED0;
      S_DN:   if (!dn_more) state_d = S_MED0;
      S_MED0: state_d = S_MED1;
      S_MED1: state_d = odd ? S_DONE : S_MED2;
      S_MED2: state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_FILL;
    endcase
    if (cfg_wr_i) state_d = S_FILL;
  end

  // Datapath and memory ports.
  always_comb begin
    fill_d      = fill_q;
    k_d         = k_q;
    idx_d       = idx_q;
    val_d       = val_q;
    old_d       = old_q;
    hi_d        = hi_q;
    median_d    = median_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_med_d   = out_med_q;
    out_bad_d   = out_bad_q;
    pv_we_o     = 1'b0;
    pv_waddr_o  = idx_q;
    pv_wdata_o  = val_q;
    pv_re_o     = 1'b0;
    pv_raddr_o  = AW'(in_if.provider_index);
    s_we_o      = 1'b0;
    s_waddr_o   = k_q;
    s_wdata_o   = val_q;
    s_re_o      = 1'b0;
    s_raddr_o   = AW'(k1);
    unique case (state_q)
      S_FILL: begin
        pv_we_o    = 1'b1;
        pv_waddr_o = fill_q;
        pv_wdata_o = init_i;
        s_we_o     = 1'b1;
        s_waddr_o  = fill_q;
        s_wdata_o  = init_i;
        fill_d     = fill_q + AW'(1);
        median_d   = init_i;
      end
      S_IDLE: begin
        pv_re_o = 1'b1;
        if (accept) begin
          idx_d = AW'(in_if.provider_index);
          val_d = in_if.new_value;
          if (bad_in) begin
            out_valid_d = 1'b1;
            out_bad_d   = 1'b1;
            out_med_d   = median_q;
          end
        end
      end
      S_PV: begin
        if (!pv_eq) begin
          old_d     = pv_rdata_i;
          pv_we_o   = 1'b1;
          k_d       = '0;
          s_re_o    = 1'b1;
          s_raddr_o = '0;
        end
      end
      S_FIND: begin
        s_re_o = 1'b1;
        if (s_eq) begin
          s_raddr_o = go_up ? AW'(k1) : (k_q - AW'(1));
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      S_UP: begin
        s_we_o = 1'b1;
        if (up_more) begin
          // Shift the larger neighbor down one slot.
          s_wdata_o = s_rdata_i;
          k_d       = k_q + AW'(1);
          s_re_o    = 1'b1;
          s_raddr_o = k_q + AW'(2);
        end
      end
      S_DN: begin
        s_we_o = 1'b1;
        if (dn_more) begin
          s_wdata_o = s_rdata_i;
          k_d       = k_q - AW'(1);
          s_re_o    = 1'b1;
          s_raddr_o = k_q - AW'(2);
        end
      end
      S_MED0: begin
        s_re_o    = 1'b1;
        s_raddr_o = AW'(mid);
      end
      S_MED1: begin
        if (odd) begin
          median_d = s_rdata_i;
        end else begin
          hi_d      = s_rdata_i;
          s_re_o    = 1'b1;
          s_raddr_o = AW'(mid - NW'(1));
        end
      end
      S_MED2: begin
        median_d = (s_rdata_i >> 1) + (hi_q >> 1) +
                   VALUE_WIDTH'(s_rdata_i[0] & hi_q[0]);
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_bad_d   = 1'b0;
          out_med_d   = median_q;
        end
      end
      default: ;
    endcase
    if (cfg_wr_i) fill_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    old_q     <= old_d;
    hi_q      <= hi_d;
    median_q  <= median_d;
    out_med_q <= out_med_d;
    out_bad_q <= out_bad_d;
  end

endmodule

// ===== src/provider_median_tracker_core.sv =====
// A bad index is answered straight from idle with bad_provider set; an unchanged
//   value skips the sort; an update finds the old value's sorted slot, moves the new
//   value to its new slot, then reads the middle slot, or both for an even count.
// Throughput: one item at a time; the sequencer walks the sorted-value memory one
//   entry per cycle.
// Reset and every config write start a refill sweep over both memories; no input
//   transfer is taken during it.
`include "provider_median_tracker_core_macros.svh"

module provider_median_tracker_core import pmt_pkg::*; #(
  parameter int MAX_PROVIDERS = DEF_MAX_PROVIDERS,
  parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pmt_in_if.sink                in_i,
  pmt_out_if.source             out_o
);

  // Address width of both memories and width of the active count.
  localparam int AW = (MAX_PROVIDERS > 1) ? $clog2(MAX_PROVIDERS) : 1;
  localparam int NW = $clog2(MAX_PROVIDERS + 1);
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

  logic [COUNT_W-1:0]     count_q, count_d;
  logic [VALUE_WIDTH-1:0] init_q, init_d;
  logic [CW-1:0]          cnt_w;
  logic [NW-1:0]          n_act;

  // Hold the config registers; any write refills the tables.
  always_comb begin
    count_d = count_q;
    init_d  = init_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COUNT: count_d = cfg_data_i[COUNT_W-1:0];
        CFG_INIT:  init_d  = cfg_data_i[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
      init_q  <= '0;
    end else begin
      count_q <= count_d;
      init_q  <= init_d;
    end
  end

  // Clamp the count to 1..MAX_PROVIDERS.
  always_comb begin
    cnt_w = CW'(count_q);
    if (cnt_w == '0) cnt_w = CW'(1);
    if (cnt_w > CW'(MAX_PROVIDERS)) cnt_w = CW'(MAX_PROVIDERS);
    n_act = NW'(cnt_w);
  end

  logic                   pv_we, pv_re, s_we, s_re;
  logic [AW-1:0]          pv_waddr, pv_raddr, s_waddr, s_raddr;
  logic [VALUE_WIDTH-1:0] pv_wdata, pv_rdata, s_wdata, s_rdata;
  pmt_stat_t              stat;

  // Per-provider values, addressed by provider index.
  pmt_ram #(.DEPTH(MAX_PROVIDERS), .AW(AW), .DW(VALUE_WIDTH)) u_pv_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .re_i    (pv_re),
    .raddr_i (pv_raddr),
    .rdata_o (pv_rdata)
  );

  // Same values kept in ascending order over slots 0..n-1.
  pmt_ram #(.DEPTH(MAX_PROVIDERS), .AW(AW), .DW(VALUE_WIDTH)) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Sequencer: look up the entry, move the changed value to its new sorted
  // slot one neighbor per cycle, then read the middle slot(s).
  pmt_ctrl #(
    .MAX_PROVIDERS (MAX_PROVIDERS),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .AW            (AW),
    .NW            (NW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_we_i),
    .n_i        (n_act),
    .init_i     (init_q),
    .in_if      (in_i),
    .out_if     (out_o),
    .pv_we_o    (pv_we),
    .pv_waddr_o (pv_waddr),
    .pv_wdata_o (pv_wdata),
    .pv_re_o    (pv_re),
    .pv_raddr_o (pv_raddr),
    .pv_rdata_i (pv_rdata),
    .s_we_o     (s_we),
    .s_waddr_o  (s_waddr),
    .s_wdata_o  (s_wdata),
    .s_re_o     (s_re),
    .s_raddr_o  (s_raddr),
    .s_rdata_i  (s_rdata),
    .stat_o     (stat)
  );

  // Take an input transfer only while the sequencer is idle.
  `PMT_ASSERT_IMPL(a_ready_only_idle, in_i.ready, !stat.busy)
  // A config write starts the refill sweep.
  `PMT_ASSERT_NEXT(a_cfg_refill, cfg_we_i, stat.filling)
  // No result is raised while the tables are being refilled.
  `PMT_ASSERT_NEXT(a_fill_no_result, stat.filling && !out_o.valid, !out_o.valid)

endmodule
